[src/rdc_pkg.sv]
package rdc_pkg;

	// Field widths and storage sizes
	localparam int VALUE_BITS  = 31;
	localparam int STACK_DEPTH = 31;
	localparam int RADIX_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int STATUS_W    = 2;

	// Derived widths
	localparam int STACK_AW = $clog2(STACK_DEPTH);
	localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
	localparam int BIT_W    = $clog2(VALUE_BITS);

	// Legal radix range
	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_DIGIT     = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_ZERO      = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_BAD_RADIX = STATUS_W'(2);

	// Controller to datapath commands
	typedef struct packed {
		logic load;     // capture a new item
		logic step;     // one restoring division step
		logic push;     // push remainder, start next digit
		logic pop;      // pop one digit into the output register
		logic special;  // load a single error or no-digits result
	} rdc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic radix_bad;
		logic value_zero;
		logic bits_done;
		logic quot_zero;
		logic cnt_one;
		logic out_free;
	} rdc_sts_t;

endpackage

[src/rdc_if.sv]
// Input channel: number and radix
interface rdc_in_if
	import rdc_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic [RADIX_W-1:0]    radix;

	modport source (output valid, output value, output radix, input ready);
	modport sink (input valid, input value, input radix, output ready);
endinterface

// Output channel: one digit per item
interface rdc_out_if
	import rdc_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [DIGIT_W-1:0]  digit;
	logic [STATUS_W-1:0] status;
	logic                last;

	modport source (output valid, output digit, output status, output last, input ready);
	modport sink (input valid, input digit, input status, input last, output ready);
endinterface

[src/rdc_datapath.sv]
module rdc_datapath
	import rdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  rdc_cmd_t              cmd,
	output rdc_sts_t              sts,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]    radix,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [DIGIT_W-1:0]    digit,
	output logic [STATUS_W-1:0]   status,
	output logic                  last
);

	logic [VALUE_BITS-1:0] val_q;
	logic [RADIX_W-1:0]    radix_q;
	logic [RADIX_W-1:0]    rem_q;
	logic [BIT_W-1:0]      bit_cnt_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIGIT_W-1:0]    stack_q [STACK_DEPTH];
	logic                  out_valid_q;
	logic [DIGIT_W-1:0]    digit_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  last_q;

	logic [RADIX_W-1:0]    trial;
	logic                  q_bit;
	logic [CNT_W-1:0]      cnt_dec;
	logic                  radix_bad;

	// Restoring division step: shift in next dividend bit, subtract if it fits
	assign trial   = {rem_q[DIGIT_W-1:0], val_q[VALUE_BITS-1]};
	assign q_bit   = (trial >= radix_q);
	assign cnt_dec = cnt_q - CNT_W'(1);

	assign radix_bad = (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX);

	// Status back to the controller
	assign sts.radix_bad  = radix_bad;
	assign sts.value_zero = (val_q == '0);
	assign sts.bits_done  = (bit_cnt_q == BIT_W'(VALUE_BITS - 1));
	assign sts.quot_zero  = (val_q == '0);
	assign sts.cnt_one    = (cnt_q == CNT_W'(1));
	assign sts.out_free   = !out_valid_q || out_ready;

	// Divider and stack control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			cnt_q     <= '0;
		end else if (cmd.load) begin
			bit_cnt_q <= '0;
			cnt_q     <= '0;
		end else if (cmd.step) begin
			bit_cnt_q <= bit_cnt_q + BIT_W'(1);
		end else if (cmd.push) begin
			bit_cnt_q <= '0;
			// saturate: more significant digits beyond the stack are dropped
			if (cnt_q < CNT_W'(STACK_DEPTH)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end else if (cmd.pop) begin
			cnt_q <= cnt_dec;
		end
	end

	// Dividend / quotient and remainder
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q   <= value;
			radix_q <= radix;
			rem_q   <= '0;
		end else if (cmd.step) begin
			val_q <= {val_q[VALUE_BITS-2:0], q_bit};
			rem_q <= q_bit ? (trial - radix_q) : trial;
		end else if (cmd.push) begin
			rem_q <= '0;
		end
	end

	// Digit stack
	always_ff @(posedge clk) begin
		if (cmd.push && (cnt_q < CNT_W'(STACK_DEPTH))) begin
			stack_q[cnt_q[STACK_AW-1:0]] <= rem_q[DIGIT_W-1:0];
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop || cmd.special) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload, stack read registered here
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			digit_q  <= stack_q[cnt_dec[STACK_AW-1:0]];
			status_q <= ST_DIGIT;
			last_q   <= (cnt_q == CNT_W'(1));
		end else if (cmd.special) begin
			digit_q  <= '0;
			status_q <= radix_bad ? ST_BAD_RADIX : ST_ZERO;
			last_q   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign digit     = digit_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

[src/rdc_ctrl.sv]
module rdc_ctrl
	import rdc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rdc_sts_t sts,
	output rdc_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SPECIAL,
		S_DIV,
		S_PUSH,
		S_POP
	} state_t;

	state_t state_q;
	logic   ready_q;

	// State and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
						ready_q <= 1'b0;
					end
				end
				S_CHECK: begin
					if (sts.radix_bad || sts.value_zero) begin
						state_q <= S_SPECIAL;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_SPECIAL: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_DIV: begin
					if (sts.bits_done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (sts.quot_zero) begin
						state_q <= S_POP;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_POP: begin
					if (sts.out_free && sts.cnt_one) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = ready_q;

	// Command decode
	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == S_IDLE) && in_valid && ready_q;
		cmd.step    = (state_q == S_DIV);
		cmd.push    = (state_q == S_PUSH);
		cmd.pop     = (state_q == S_POP) && sts.out_free;
		cmd.special = (state_q == S_SPECIAL) && sts.out_free;
	end

endmodule

[src/radix_digit_converter.sv]
// Radix digit converter: repeated division by a bit-serial restoring divider.
// After an item is taken: a check state, then divider steps and a push for each digit,
// then one pop per digit. One item is in work at a time: the input is not ready again
// until its last result is loaded into the output register. A bad radix or zero value
// gives a single special result. Outputs stall on ready.
// Reset: arst_n clears the controller and counters; the digit stack is not cleared.
module radix_digit_converter
	import rdc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	rdc_in_if.sink     num,
	rdc_out_if.source  dig
);

	rdc_cmd_t cmd;
	rdc_sts_t sts;

	rdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (num.valid),
		.in_ready (num.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rdc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (num.value),
		.radix     (num.radix),
		.out_ready (dig.ready),
		.out_valid (dig.valid),
		.digit     (dig.digit),
		.status    (dig.status),
		.last      (dig.last)
	);

endmodule

[src/rdc_checker.sv]
module rdc_checker
	import rdc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [DIGIT_W-1:0]  digit,
	input logic [STATUS_W-1:0] status,
	input logic                last
);

	// A result item waits until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// Only defined status codes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_DIGIT || status == ST_ZERO || status == ST_BAD_RADIX))
		else $error("undefined status code");

	// Error and no-digit results are single items with digit zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DIGIT |-> last && digit == '0)
		else $error("special result not a lone zero item");

	// One item in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (num.valid),
	.in_ready  (num.ready),
	.out_valid (dig.valid),
	.out_ready (dig.ready),
	.digit     (dig.digit),
	.status    (dig.status),
	.last      (dig.last)
);
